// ===== hdl/ppdq_pkg.sv =====
// shared types and constants of the parity partitioned deque
package ppdq_pkg;

    localparam int DEF_CLASS_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int DATA_W   = 32;   // popped value / pushed value field
    localparam int LEN_W    = 6;    // total length field
    localparam int S_TDATA_W = 40;  // opcode + value, padded to bytes
    localparam int M_TDATA_W = 40;  // popped value + status + length

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FIRST  = 2'd2,
        OP_POP_LAST   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ODD  = 2'd1,
        SRC_EVEN = 2'd2
    } t_src;

    // one operation handed to a class ring
    typedef struct packed {
        logic push;
        logic pop;
        logic at_front;
    } t_ring_cmd;

endpackage

// ===== hdl/parity_partitioned_deque.sv =====
// top level of the parity partitioned deque: dispatch, two class rings, result pipeline
//
//  channel  | dir | beat fields (lowest bit first)
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tdata: opcode[1:0], value[33:2], zero pad[39:34]
//  m_axis   | out | tdata: popped_value[31:0], status[33:32], total_length[39:34]
//
//  one beat in and one beat out per cycle when neither side stalls
//  each result passes the read stage (ring update and store read), then the output register
//  ring pointers and counts move at the edge that accepts a beat, so the next
//  beat sees them at once
//  i_rst_n (synchronous) empties both rings; stores hold junk until written
//  a stalled output register holds the read stage, which then stalls s_axis
module parity_partitioned_deque #(
    parameter int CLASS_DEPTH = ppdq_pkg::DEF_CLASS_DEPTH,
    parameter int VALUE_WIDTH = ppdq_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ppdq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // opcode, value, pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ppdq_pkg::M_TDATA_W-1:0] m_axis_tdata   // popped_value, status, total_length
);
    import ppdq_pkg::*;

    localparam int CW  = $clog2(CLASS_DEPTH + 1);
    localparam int LW  = ((CW + 1) > LEN_W) ? (CW + 1) : LEN_W;
    localparam int MW  = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

    // input beat fields
    t_opcode                  in_op;
    logic [DATA_W-1:0]        in_value;
    logic [MW-1:0]            in_wide;
    logic [VALUE_WIDTH-1:0]   in_stored;
    logic                     in_odd;

    logic                     accept;
    logic                     s1_adv;

    t_ring_cmd                odd_cmd;
    t_ring_cmd                even_cmd;
    logic [CW-1:0]            odd_count;
    logic [CW-1:0]            even_count;
    logic [VALUE_WIDTH-1:0]   odd_rdata;
    logic [VALUE_WIDTH-1:0]   even_rdata;

    t_status                  c_status;
    t_src                     c_src;
    logic                     c_push_ok;
    logic                     c_pop_ok;
    logic [LW-1:0]            c_len;

    // read stage: store data arrives here, metadata waits beside it
    logic                     r_s1_valid;
    t_status                  r_s1_status;
    t_src                     r_s1_src;
    logic [LEN_W-1:0]         r_s1_len;

    // output register
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_value;
    t_status                  r_out_status;
    logic [LEN_W-1:0]         r_out_len;

    logic [MW-1:0]            pop_wide;
    logic [DATA_W-1:0]        pop_value;

    assign in_op     = t_opcode'(s_axis_tdata[1:0]);
    assign in_value  = s_axis_tdata[DATA_W+1:2];
    assign in_wide   = MW'(in_value);
    assign in_stored = in_wide[VALUE_WIDTH-1:0];
    // parity is bit zero, which also sorts negative values correctly
    assign in_odd    = in_value[0];

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // dispatch: pick the ring, refuse full pushes and empty pops
    always_comb begin
        odd_cmd   = '0;
        even_cmd  = '0;
        c_status  = ST_OK;
        c_src     = SRC_NONE;
        c_push_ok = 1'b0;
        c_pop_ok  = 1'b0;
        if (accept) begin
            case (in_op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (in_odd) begin
                        if (odd_count == CW'(CLASS_DEPTH)) begin
                            c_status = ST_FULL;
                        end else begin
                            odd_cmd.push     = 1'b1;
                            odd_cmd.at_front = (in_op == OP_PUSH_FRONT);
                            c_push_ok        = 1'b1;
                        end
                    end else begin
                        if (even_count == CW'(CLASS_DEPTH)) begin
                            c_status = ST_FULL;
                        end else begin
                            even_cmd.push     = 1'b1;
                            even_cmd.at_front = (in_op == OP_PUSH_FRONT);
                            c_push_ok         = 1'b1;
                        end
                    end
                end
                OP_POP_FIRST: begin
                    // logical first: odd front, else even front
                    if (odd_count != '0) begin
                        odd_cmd.pop      = 1'b1;
                        odd_cmd.at_front = 1'b1;
                        c_src            = SRC_ODD;
                        c_pop_ok         = 1'b1;
                    end else if (even_count != '0) begin
                        even_cmd.pop      = 1'b1;
                        even_cmd.at_front = 1'b1;
                        c_src             = SRC_EVEN;
                        c_pop_ok          = 1'b1;
                    end else begin
                        c_status = ST_EMPTY;
                    end
                end
                OP_POP_LAST: begin
                    // logical last: even back, else odd back
                    if (even_count != '0) begin
                        even_cmd.pop = 1'b1;
                        c_src        = SRC_EVEN;
                        c_pop_ok     = 1'b1;
                    end else if (odd_count != '0) begin
                        odd_cmd.pop = 1'b1;
                        c_src       = SRC_ODD;
                        c_pop_ok    = 1'b1;
                    end else begin
                        c_status = ST_EMPTY;
                    end
                end
                default: begin
                    c_status = ST_OK;
                end
            endcase
        end
    end

    // length after this beat, wrapped to the field width
    assign c_len = LW'(odd_count) + LW'(even_count) + LW'(c_push_ok) - LW'(c_pop_ok);

    ppdq_ring #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_odd_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (odd_cmd),
        .i_value (in_stored),
        .o_count (odd_count),
        .o_rdata (odd_rdata)
    );

    ppdq_ring #(
        .CLASS_DEPTH (CLASS_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_even_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (even_cmd),
        .i_value (in_stored),
        .o_count (even_count),
        .o_rdata (even_rdata)
    );

    // popped value from the ring that was read, zero for everything else
    always_comb begin
        case (r_s1_src)
            SRC_ODD:  pop_wide = MW'(odd_rdata);
            SRC_EVEN: pop_wide = MW'(even_rdata);
            default:  pop_wide = '0;
        endcase
        pop_value = pop_wide[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= c_status;
            r_s1_src    <= c_src;
            r_s1_len    <= c_len[LEN_W-1:0];
        end
        if (s1_adv && r_s1_valid) begin
            r_out_value  <= pop_value;
            r_out_status <= r_s1_status;
            r_out_len    <= r_s1_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_status, r_out_value};

    // at most one ring moves per beat
    a_one_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((odd_cmd.push || odd_cmd.pop) && (even_cmd.push || even_cmd.pop)))
        else $error("both rings commanded in one cycle");

    // rings only move on an accepted beat
    a_cmd_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (odd_cmd.push || odd_cmd.pop || even_cmd.push || even_cmd.pop) |-> accept)
        else $error("ring command without accepted beat");

    // a stalled read stage keeps its beat
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("read stage dropped a stalled beat");

    // counts never pass the class depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (odd_count <= CW'(CLASS_DEPTH)) && (even_count <= CW'(CLASS_DEPTH)))
        else $error("ring count beyond depth");

    // a pop read is never issued to an empty ring
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (odd_cmd.pop |-> odd_count != '0) and (even_cmd.pop |-> even_count != '0))
        else $error("pop issued to empty ring");

endmodule

// ===== hdl/ppdq_ring.sv =====
// one bounded ring-buffer deque: store, head pointer and fill count
module ppdq_ring #(
    parameter int CLASS_DEPTH = ppdq_pkg::DEF_CLASS_DEPTH,
    parameter int VALUE_WIDTH = ppdq_pkg::DEF_VALUE_WIDTH,
    localparam int CW = $clog2(CLASS_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ppdq_pkg::t_ring_cmd    i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic [CW-1:0]          o_count,
    output logic [VALUE_WIDTH-1:0] o_rdata
);
    import ppdq_pkg::*;

    localparam int AW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int SW = AW + 1;

    logic [VALUE_WIDTH-1:0] r_store [CLASS_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;
    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          n_head;
    logic [CW-1:0]          n_count;

    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] back_sum;
    logic [AW-1:0] back_idx;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    // back slot: head + count on push, head + count - 1 on pop, below twice the depth
    always_comb begin
        head_dec = (r_head == '0) ? AW'(CLASS_DEPTH - 1) : r_head - AW'(1);
        head_inc = (r_head == AW'(CLASS_DEPTH - 1)) ? '0 : r_head + AW'(1);
        back_sum = SW'(r_head) + SW'(r_count) - SW'(i_cmd.pop);
        if (back_sum >= SW'(CLASS_DEPTH)) begin
            back_idx = AW'(back_sum - SW'(CLASS_DEPTH));
        end else begin
            back_idx = back_sum[AW-1:0];
        end
        waddr = i_cmd.at_front ? head_dec : back_idx;
        raddr = i_cmd.at_front ? r_head : back_idx;
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            if (i_cmd.at_front) begin
                n_head = head_dec;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            if (i_cmd.at_front) begin
                n_head = head_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_store[waddr] <= i_value;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_store[raddr];
        end
    end

    assign o_count = r_count;
    assign o_rdata = r_rdata;

endmodule
